>>> src/tcta_pkg.sv
// Shared types and constants for the top-count table with ageing.
// No dependencies; imported by every module of the block.
package tcta_pkg;

  localparam int TABLE_ENTRIES   = 16;
  localparam int TOP_LIST_LENGTH = 10;
  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int NUM_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int RANK_W = 4;
  localparam int KEY_W  = 64;
  localparam int VAL_W  = 32;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_INTERVAL = 2'd1;

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] count;
    logic [VAL_W-1:0] event_time;
  } in_word_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [KEY_W-1:0]  key_res;
    logic [VAL_W-1:0]  count_res;
    logic [VAL_W-1:0]  event_time_res;
    logic              valid_res;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] count;
    logic [VAL_W-1:0] etime;
  } entry_t;

  // Candidate against current best: rank order and eviction order.
  typedef struct packed {
    logic above;
    logic older;
  } cmp_res_t;

endpackage

>>> src/top_count_table_with_aging_top.sv
// Top level of the top-count table with ageing: sequencer, table and registers.
// Depends on tcta_pkg and tcta_cmp.
//
// Usage:
//   in_*  : one word per item. kind 0 is an update (key, count, event_time),
//           kind 1 reads the top list. in_ready is high only while idle.
//   out_* : a read gives one word per ranked entry, rank 0 first, last set on
//           the final word; an empty table gives a single word with valid_res
//           low and last high. Updates give no words.
//   cfg_* : register writes (index 0 max_age, index 1 sweep_interval), taken
//           at any time; cfg_ready is always high.
// Sequence (16 entries): an update runs an ageing scan, then a search scan and
//   a write; an update with key or count zero stops after ageing. Scans walk
//   the table one entry a cycle through the single table read port; the search
//   and rank scans share the comparator.
//   A read runs a full rank scan for each ranked word, then hands the word over
//   through the output register.
// Stall: a word waits in the output register until out_ready; the sequencer
//   holds until then.
// Reset: all entries empty, last sweep time zero, max_age 3600,
//   sweep_interval 60.
module top_count_table_with_aging_top import tcta_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_AGE   = 3'd1;
  localparam logic [2:0] ST_SRCH  = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_RANK  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

  logic [2:0]               state;
  logic [IDX_W-1:0]         idx;
  logic [TABLE_ENTRIES-1:0] used;
  logic [TABLE_ENTRIES-1:0] taken;
  entry_t                   table_q [TABLE_ENTRIES];
  logic [VAL_W-1:0]         last_sweep;
  logic [VAL_W-1:0]         max_age;
  logic [VAL_W-1:0]         sweep_interval;
  in_word_t                 req;
  logic                     age_run;
  logic [VAL_W-1:0]         bound;
  logic                     best_found;
  logic [IDX_W-1:0]         best_idx;
  entry_t                   best;
  logic                     match_found;
  logic [IDX_W-1:0]         match_idx;
  logic                     free_found;
  logic [IDX_W-1:0]         free_idx;
  logic [RANK_W-1:0]        rank;
  logic [NUM_W-1:0]         n_out;

  entry_t           cur;
  cmp_res_t         cmp;
  logic             due;
  logic [NUM_W-1:0] used_num;
  logic [VAL_W:0]   sat_sum;
  logic [IDX_W-1:0] slot;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign cur       = table_q[idx];

  tcta_cmp u_cmp (
    .cand (cur),
    .best (best),
    .res  (cmp)
  );

  // 33-bit sum so the interval never wraps
  assign due = (last_sweep == '0) ||
               (({1'b0, last_sweep} + {1'b0, sweep_interval}) < {1'b0, in_word.event_time});
  assign used_num = NUM_W'($countones(used));
  assign sat_sum  = {1'b0, table_q[match_idx].count} + {1'b0, req.count};
  assign slot     = free_found ? free_idx : best_idx;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_age        <= VAL_W'(3600);
      sweep_interval <= VAL_W'(60);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_MAX_AGE)        max_age        <= cfg_data;
      if (cfg_index == REG_SWEEP_INTERVAL) sweep_interval <= cfg_data;
    end
  end

  // Table payload: no reset; a slot's contents only count once its used bit is set
  always_ff @(posedge clk) begin
    if (state == ST_WRITE) begin
      if (match_found) begin
        table_q[match_idx].count <= sat_sum[VAL_W] ? '1 : sat_sum[VAL_W-1:0];
        if (req.event_time > table_q[match_idx].etime) begin
          table_q[match_idx].etime <= req.event_time;
        end
      end else begin
        table_q[slot] <= '{key: req.key, count: req.count, etime: req.event_time};
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      used       <= '0;
      last_sweep <= '0;
      out_valid  <= 1'b0;
      idx        <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req         <= in_word;
            idx         <= '0;
            best_found  <= 1'b0;
            match_found <= 1'b0;
            free_found  <= 1'b0;
            taken       <= '0;
            rank        <= '0;
            if (in_word.kind == KIND_READ) begin
              n_out <= (used_num > NUM_W'(TOP_LIST_LENGTH)) ?
                       NUM_W'(TOP_LIST_LENGTH) : used_num;
              if (used_num == '0) begin
                // empty table: one blank word marked last
                out_word  <= '{rank: '0, key_res: '0, count_res: '0,
                               event_time_res: '0, valid_res: 1'b0, last: 1'b1};
                out_valid <= 1'b1;
                state     <= ST_EMIT;
              end else begin
                state <= ST_RANK;
              end
            end else begin
              age_run <= due;
              if (due) last_sweep <= in_word.event_time;
              bound <= (in_word.event_time > max_age) ?
                       (in_word.event_time - max_age) : '0;
              state <= ST_AGE;
            end
          end
        end
        ST_AGE: begin
          // when a sweep is due, drop stale entries one per cycle
          if (age_run && used[idx] && (cur.etime < bound)) used[idx] <= 1'b0;
          idx <= idx + 1'b1;
          if (idx == IDX_LAST) begin
            idx   <= '0;
            state <= ((req.key == '0) || (req.count == '0)) ? ST_IDLE : ST_SRCH;
          end
        end
        ST_SRCH: begin
          if (used[idx] && (cur.key == req.key) && !match_found) begin
            match_found <= 1'b1;
            match_idx   <= idx;
          end
          if (!used[idx] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= idx;
          end
          // eviction candidate; only used when every slot is taken
          if (!best_found || cmp.older) begin
            best_found <= 1'b1;
            best_idx   <= idx;
            best       <= cur;
          end
          idx <= idx + 1'b1;
          if (idx == IDX_LAST) state <= ST_WRITE;
        end
        ST_WRITE: begin
          if (!match_found) used[slot] <= 1'b1;
          idx   <= '0;
          state <= ST_IDLE;
        end
        ST_RANK: begin
          if (used[idx] && !taken[idx] && (!best_found || cmp.above)) begin
            best_found <= 1'b1;
            best_idx   <= idx;
            best       <= cur;
          end
          idx <= idx + 1'b1;
          if (idx == IDX_LAST) begin
            state <= ST_EMIT;
            // n_out >= 1 here, so the scan always finds a candidate
            if (used[idx] && !taken[idx] && (!best_found || cmp.above)) begin
              taken[idx] <= 1'b1;
              out_word   <= '{rank: rank, key_res: cur.key, count_res: cur.count,
                              event_time_res: cur.etime, valid_res: 1'b1,
                              last: (NUM_W'(rank) == n_out - 1'b1)};
            end else begin
              taken[best_idx] <= 1'b1;
              out_word <= '{rank: rank, key_res: best.key, count_res: best.count,
                            event_time_res: best.etime, valid_res: 1'b1,
                            last: (NUM_W'(rank) == n_out - 1'b1)};
            end
            out_valid <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_ready) begin
            out_valid  <= 1'b0;
            idx        <= '0;
            best_found <= 1'b0;
            rank       <= rank + 1'b1;
            state      <= out_word.last ? ST_IDLE : ST_RANK;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_out_only_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == ST_EMIT))
    else $error("output word valid outside emit state");

  a_rank_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.valid_res) |-> (NUM_W'(out_word.rank) < n_out))
    else $error("rank beyond list length");

  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.valid_res && out_word.last) |->
      (NUM_W'(out_word.rank) == n_out - 1'b1))
    else $error("last flag on wrong rank");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_AGE || state == ST_SRCH || state == ST_RANK) |-> !in_ready)
    else $error("input ready while busy");

endmodule

>>> src/tcta_cmp.sv
// Shared entry comparator used by the search and rank scans.
// Depends on tcta_pkg.
module tcta_cmp import tcta_pkg::*; (
  input  entry_t   cand,
  input  entry_t   best,
  output cmp_res_t res
);

  always_comb begin
    // rank: count descending, then newer time, then smaller key
    if (cand.count != best.count) begin
      res.above = cand.count > best.count;
    end else if (cand.etime != best.etime) begin
      res.above = cand.etime > best.etime;
    end else begin
      res.above = cand.key < best.key;
    end
    // eviction: oldest time, then smaller key
    res.older = (cand.etime < best.etime) ||
                ((cand.etime == best.etime) && (cand.key < best.key));
  end

endmodule

>>> tb/tcta_scoreboard.sv
// Checker for the top-count table: watches the input, output and register channels,
// keeps its own copy of the table and compares every output word.
// Depends on tcta_pkg.
module tcta_scoreboard import tcta_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_word_t             in_word,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_word_t            out_word,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data,
  output int                   errors,
  output int                   pending
);

  logic             slot_used [TABLE_ENTRIES];
  logic [KEY_W-1:0] slot_key  [TABLE_ENTRIES];
  logic [VAL_W-1:0] slot_cnt  [TABLE_ENTRIES];
  logic [VAL_W-1:0] slot_time [TABLE_ENTRIES];
  logic [VAL_W-1:0] last_sweep;
  logic [VAL_W-1:0] age_limit;
  logic [VAL_W-1:0] sweep_gap;
  out_word_t        ranked_words [$];

  function automatic void sweep_old(logic [VAL_W-1:0] now);
    logic [VAL_W:0]   due;
    logic [VAL_W-1:0] bound;
    due = {1'b0, last_sweep} + {1'b0, sweep_gap};
    if (last_sweep != '0 && !(due < {1'b0, now})) return;
    last_sweep = now;
    bound = (now > age_limit) ? now - age_limit : '0;
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (slot_used[i] && slot_time[i] < bound) slot_used[i] = 1'b0;
  endfunction

  function automatic bit outranks(int a, int b);
    if (slot_cnt[a] != slot_cnt[b]) return slot_cnt[a] > slot_cnt[b];
    if (slot_time[a] != slot_time[b]) return slot_time[a] > slot_time[b];
    return slot_key[a] < slot_key[b];
  endfunction

  function automatic void count_event(logic [KEY_W-1:0] k, logic [VAL_W-1:0] c,
                                      logic [VAL_W-1:0] now);
    logic [VAL_W:0] sum;
    int slot;
    slot = -1;
    sweep_old(now);
    if (k == '0 || c == '0) return;
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (slot_used[i] && slot_key[i] == k) begin
        sum = {1'b0, slot_cnt[i]} + {1'b0, c};
        slot_cnt[i] = sum[VAL_W] ? '1 : sum[VAL_W-1:0];
        if (now > slot_time[i]) slot_time[i] = now;
        return;
      end
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (!slot_used[i] && slot < 0) slot = i;
    // full: evict the oldest, smaller key on equal times
    if (slot < 0)
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (slot < 0 || slot_time[i] < slot_time[slot] ||
            (slot_time[i] == slot_time[slot] && slot_key[i] < slot_key[slot]))
          slot = i;
    slot_used[slot] = 1'b1;
    slot_key[slot]  = k;
    slot_cnt[slot]  = c;
    slot_time[slot] = now;
  endfunction

  function automatic void rank_table();
    bit        taken [TABLE_ENTRIES];
    int        used_n, n, best;
    out_word_t w;
    used_n = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      taken[i] = 0;
      if (slot_used[i]) used_n++;
    end
    if (used_n == 0) begin
      w = '0;
      w.last = 1'b1;
      ranked_words = {ranked_words, w};
      return;
    end
    n = (used_n < TOP_LIST_LENGTH) ? used_n : TOP_LIST_LENGTH;
    for (int r = 0; r < n; r++) begin
      best = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (slot_used[i] && !taken[i] && (best < 0 || outranks(i, best))) best = i;
      taken[best]      = 1;
      w.rank           = r[RANK_W-1:0];
      w.key_res        = slot_key[best];
      w.count_res      = slot_cnt[best];
      w.event_time_res = slot_time[best];
      w.valid_res      = 1'b1;
      w.last           = (r == n - 1);
      ranked_words = {ranked_words, w};
    end
  endfunction

  function automatic int field_diff(string f, logic [KEY_W-1:0] exp_v,
                                    logic [KEY_W-1:0] got_v);
    if (exp_v === got_v) return 0;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, f, exp_v, got_v);
    return 1;
  endfunction

  always @(posedge clk) begin
    out_word_t e;
    int bad;
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        slot_used[i] = 1'b0;
        slot_key[i]  = '0;
        slot_cnt[i]  = '0;
        slot_time[i] = '0;
      end
      last_sweep = '0;
      age_limit  = 32'd3600;
      sweep_gap  = 32'd60;
      ranked_words.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MAX_AGE) age_limit = cfg_data;
        else if (cfg_index == REG_SWEEP_INTERVAL) sweep_gap = cfg_data;
      end
      if (in_valid && in_ready) begin
        if (in_word.kind == KIND_READ) rank_table();
        else count_event(in_word.key, in_word.count, in_word.event_time);
      end
      if (out_valid && out_ready) begin
        if (ranked_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %0h", $time, out_word);
          errors++;
        end else begin
          e = ranked_words.pop_front();
          bad = field_diff("rank", e.rank, out_word.rank)
              + field_diff("key_res", e.key_res, out_word.key_res)
              + field_diff("count_res", e.count_res, out_word.count_res)
              + field_diff("event_time_res", e.event_time_res, out_word.event_time_res)
              + field_diff("valid_res", e.valid_res, out_word.valid_res)
              + field_diff("last", e.last, out_word.last);
          if (bad != 0) errors++;
        end
      end
    end
    pending = ranked_words.size();
  end

endmodule

>>> tb/tb_top_count_table_with_aging_top.sv
// Stimulus and verdict for the top-count table with ageing.
// Depends on tcta_pkg, tcta_scoreboard and the block's top level.
module tb_top_count_table_with_aging_top;
  import tcta_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  in_word_t             in_word;
  logic                 out_valid;
  logic                 out_ready;
  out_word_t            out_word;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [VAL_W-1:0]     cfg_data;
  int                   errors;
  int                   pending;

  // calm: no idling on either side; hold_req: ask the receiver for a long hold-off
  bit                   calm;
  logic                 hold_req;
  bit                   hold_done;
  logic [VAL_W-1:0]     now;
  logic [KEY_W-1:0]     key_pool [24];

  top_count_table_with_aging_top uut (.*);

  tcta_scoreboard chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: random stall bursts, stretches of steady ready, one long hold-off.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // Offer one word and hold it until taken; valid stays high on return.
  task automatic send(in_word_t w);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drop valid, wait for every expected word, then let a trailing update finish.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_word_t upd(logic [KEY_W-1:0] k, logic [VAL_W-1:0] c,
                                   logic [VAL_W-1:0] t);
    in_word_t w;
    w.kind       = KIND_UPDATE;
    w.key        = k;
    w.count      = c;
    w.event_time = t;
    return w;
  endfunction

  function automatic in_word_t rd();
    in_word_t w;
    w      = {1'b0, $urandom, $urandom, $urandom, $urandom};
    w.kind = KIND_READ;
    return w;
  endfunction

  // Mostly a small key set on a slowly rising clock, so keys match, age and evict.
  function automatic in_word_t random_item();
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] c;
    int               pick;
    if ($urandom_range(0, 4) == 0) return rd();
    pick = $urandom_range(0, 99);
    if (pick < 5) k = '0;
    else if (pick < 80) k = key_pool[$urandom_range(0, 23)];
    else k = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 8) c = '0;
    else if (pick < 75) c = $urandom_range(1, 100);
    else c = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 4) now = $urandom;
    else if (pick < 10) now = now - $urandom_range(0, 50);
    else now = now + $urandom_range(0, 40);
    return upd(k, c, now);
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      send(random_item());
      if (!calm && $urandom_range(0, 4) == 0) pause($urandom_range(1, 15));
    end
  endtask

  task automatic new_pool();
    key_pool[0] = '1;
    key_pool[1] = 64'd1;
    for (int i = 2; i < 24; i++)
      key_pool[i] = ($urandom_range(0, 1) != 0) ? {$urandom, $urandom} :
                    KEY_W'($urandom_range(2, 40));
  endtask

  initial begin
    calm      = 1'b0;
    hold_req  <= 1'b0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_word   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_MAX_AGE;
    cfg_data  <= '0;
    now       = 32'd100;
    new_pool();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty read, ageing-only updates, saturation, older time, ties.
    send(rd());
    send(upd('0, 32'd7, 32'd10));
    send(upd(64'd5, '0, 32'd20));
    send(upd(64'd5, 32'd3, 32'd30));
    send(upd(64'd5, 32'd4, 32'd25));
    send(upd('1, 32'hFFFF_FFF0, 32'd40));
    send(upd('1, 32'd100, 32'd41));
    send(upd(64'd9, 32'd7, 32'd30));
    send(upd(64'd3, 32'd7, 32'd30));
    send(rd());
    // overfill with equal times to force eviction by key
    for (int i = 0; i < 14; i++) send(upd(64'd100 + i, 32'd1, 32'd50));
    send(rd());
    send(upd(64'h8000_0000_0000_0001, 32'h8000_0000, 32'hFFFF_FFFF));
    send(rd());
    drain();

    // Extremes of both registers, then mid values.
    write_reg(REG_MAX_AGE, '0);
    write_reg(REG_SWEEP_INTERVAL, '0);
    now = 32'd10;
    random_phase(70);
    drain();

    write_reg(REG_MAX_AGE, '1);
    write_reg(REG_SWEEP_INTERVAL, '1);
    new_pool();
    now = 32'hFFFF_FF00;
    random_phase(70);

    // Long receiver hold-off with reads queued behind it.
    hold_req <= 1'b1;
    for (int i = 0; i < 6; i++) send(rd());
    drain();

    write_reg(REG_MAX_AGE, 32'd200);
    write_reg(REG_SWEEP_INTERVAL, 32'd15);
    new_pool();
    now = 32'd1000;
    random_phase(100);
    drain();

    write_reg(REG_MAX_AGE, $urandom_range(50, 2000));
    write_reg(REG_SWEEP_INTERVAL, $urandom_range(0, 100));
    random_phase(80);
    drain();

    // Final stretch at full rate on both sides.
    calm = 1'b1;
    write_reg(REG_MAX_AGE, 32'd3600);
    write_reg(REG_SWEEP_INTERVAL, 32'd60);
    random_phase(60);
    drain();

    if (errors == 0)
      $display("tb_top_count_table_with_aging_top: done, clean");
    else
      $display("tb_top_count_table_with_aging_top: done, errors");
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_top_count_table_with_aging_top: done, errors");
    $finish;
  end

endmodule
